>>> hdl/u8sd_pkg.sv
// Shared types, codes and helper functions for the UTF-8 stream decoder.
package u8sd_pkg;

    localparam int OFFSET_WIDTH = 32;
    localparam int CP_WIDTH     = 21;

    localparam logic [2:0] CLS_ASCII = 3'd0;
    localparam logic [2:0] CLS_LEAD2 = 3'd1;
    localparam logic [2:0] CLS_LEAD3 = 3'd2;
    localparam logic [2:0] CLS_LEAD4 = 3'd3;
    localparam logic [2:0] CLS_CONT  = 3'd4;
    localparam logic [2:0] CLS_BAD   = 3'd5;

    localparam logic [2:0] ST_PENDING = 3'd0;
    localparam logic [2:0] ST_DONE    = 3'd1;
    localparam logic [2:0] ST_BADSEQ  = 3'd2;
    localparam logic [2:0] ST_ORPHAN  = 3'd3;
    localparam logic [2:0] ST_BADBYTE = 3'd4;
    localparam logic [2:0] ST_END     = 3'd5;

    localparam logic [CP_WIDTH-1:0] CP_MAX       = 21'h10FFFF;
    localparam logic [CP_WIDTH-1:0] SURR_LOW     = 21'h00D800;
    localparam logic [CP_WIDTH-1:0] SURR_HIGH    = 21'h00DFFF;
    localparam logic [CP_WIDTH-1:0] MIN_TWO      = 21'h000080;
    localparam logic [CP_WIDTH-1:0] MIN_THREE    = 21'h000800;
    localparam logic [CP_WIDTH-1:0] MIN_FOUR     = 21'h010000;

    typedef struct packed {
        logic [CP_WIDTH-1:0]     partial;
        logic [1:0]              collected;
        logic [1:0]              remaining;
        logic [2:0]              seq_len;
        logic [OFFSET_WIDTH-1:0] position;
    } seq_state_t;

    typedef struct packed {
        logic [31:0]         byte_offset;
        logic [2:0]          byte_class;
        logic [1:0]          dropped_length;
        logic [2:0]          status;
        logic [CP_WIDTH-1:0] code_point;
    } result_t;

    // Sorts a raw byte into its UTF-8 role.
    function automatic logic [2:0] classify(input logic [7:0] b);
        logic [2:0] cls;
        if (b <= 8'h7F)      cls = CLS_ASCII;
        else if (b <= 8'hBF) cls = CLS_CONT;
        else if (b <= 8'hC1) cls = CLS_BAD;
        else if (b <= 8'hDF) cls = CLS_LEAD2;
        else if (b <= 8'hEF) cls = CLS_LEAD3;
        else if (b <= 8'hF4) cls = CLS_LEAD4;
        else                 cls = CLS_BAD;
        return cls;
    endfunction

    // Rejects overlong forms, surrogates and values beyond the Unicode range.
    function automatic logic value_ok(input logic [CP_WIDTH-1:0] cp, input logic [2:0] len);
        logic ok;
        case (len)
            3'd2:    ok = (cp >= MIN_TWO);
            3'd3:    ok = (cp >= MIN_THREE) && !((cp >= SURR_LOW) && (cp <= SURR_HIGH));
            3'd4:    ok = (cp >= MIN_FOUR) && (cp <= CP_MAX);
            default: ok = 1'b0;
        endcase
        return ok;
    endfunction

endpackage

>>> hdl/u8sd_step.sv
// Combinational decode step: one word against the current sequence state.
module u8sd_step
(
    input  logic [7:0]             in_byte,
    input  logic                   in_end,
    input  u8sd_pkg::seq_state_t   cur,
    output u8sd_pkg::seq_state_t   nxt,
    output u8sd_pkg::result_t      res
);

    logic [2:0]                          cls;
    logic                                open_seq;
    logic [u8sd_pkg::CP_WIDTH-1:0]       shifted;
    logic [1:0]                          rem_dec;
    logic [63:0]                         pos_ext;

    assign cls      = u8sd_pkg::classify(in_byte);
    assign open_seq = (cur.collected != 2'd0);
    assign shifted  = {cur.partial[u8sd_pkg::CP_WIDTH-7:0], in_byte[5:0]};
    assign rem_dec  = cur.remaining - 2'd1;
    assign pos_ext  = 64'(cur.position);

    always_comb
    begin
        nxt                = cur;
        res.byte_offset    = pos_ext[31:0];
        res.byte_class     = u8sd_pkg::CLS_ASCII;
        res.dropped_length = 2'd0;
        res.status         = u8sd_pkg::ST_PENDING;
        res.code_point     = '0;

        if (in_end)
        begin
            res.dropped_length = cur.collected;
            res.status         = u8sd_pkg::ST_END;
            nxt.partial        = '0;
            nxt.collected      = 2'd0;
            nxt.remaining      = 2'd0;
            nxt.seq_len        = 3'd0;
        end
        else
        begin
            nxt.position   = cur.position + {{(u8sd_pkg::OFFSET_WIDTH-1){1'b0}}, 1'b1};
            res.byte_class = cls;
            // Anything but a continuation abandons an open sequence.
            if (open_seq && (cls != u8sd_pkg::CLS_CONT))
            begin
                res.dropped_length = cur.collected;
                nxt.partial        = '0;
                nxt.collected      = 2'd0;
                nxt.remaining      = 2'd0;
                nxt.seq_len        = 3'd0;
            end
            case (cls)
                u8sd_pkg::CLS_ASCII:
                begin
                    res.status     = u8sd_pkg::ST_DONE;
                    res.code_point = u8sd_pkg::CP_WIDTH'(in_byte);
                end
                u8sd_pkg::CLS_LEAD2:
                begin
                    nxt.seq_len   = 3'd2;
                    nxt.remaining = 2'd1;
                    nxt.collected = 2'd1;
                    nxt.partial   = u8sd_pkg::CP_WIDTH'(in_byte[4:0]);
                end
                u8sd_pkg::CLS_LEAD3:
                begin
                    nxt.seq_len   = 3'd3;
                    nxt.remaining = 2'd2;
                    nxt.collected = 2'd1;
                    nxt.partial   = u8sd_pkg::CP_WIDTH'(in_byte[3:0]);
                end
                u8sd_pkg::CLS_LEAD4:
                begin
                    nxt.seq_len   = 3'd4;
                    nxt.remaining = 2'd3;
                    nxt.collected = 2'd1;
                    nxt.partial   = u8sd_pkg::CP_WIDTH'(in_byte[2:0]);
                end
                u8sd_pkg::CLS_CONT:
                begin
                    if (open_seq && (cur.remaining != 2'd0))
                    begin
                        if (rem_dec == 2'd0)
                        begin
                            if (u8sd_pkg::value_ok(shifted, cur.seq_len))
                            begin
                                res.status     = u8sd_pkg::ST_DONE;
                                res.code_point = shifted;
                            end
                            else
                            begin
                                res.status = u8sd_pkg::ST_BADSEQ;
                            end
                            nxt.partial   = '0;
                            nxt.collected = 2'd0;
                            nxt.remaining = 2'd0;
                            nxt.seq_len   = 3'd0;
                        end
                        else
                        begin
                            nxt.partial   = shifted;
                            nxt.collected = cur.collected + 2'd1;
                            nxt.remaining = rem_dec;
                        end
                    end
                    else
                    begin
                        res.status = u8sd_pkg::ST_ORPHAN;
                    end
                end
                default:
                begin
                    res.status = u8sd_pkg::ST_BADBYTE;
                end
            endcase
        end
    end

endmodule

>>> hdl/utf8_stream_decoder_core.sv
// Top level of the UTF-8 stream decoder and validator.
// An accepted word passes through the input register, then the result register.
// Throughput: one word per cycle while the result side is not stalled; the decode state update is combinational.
// A stalled result holds the output register, and the input register then holds one word.
// Reset (rst_n low, asynchronous) closes any open sequence and clears the byte offset.
// Payload registers are not reset; only valid flags and sequence state are.
module utf8_stream_decoder_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // stream_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // [31:0] byte_offset, [33:32] dropped_length,
                                   // [54:34] code_point, [55] zero
    output logic [5:0]  m_tuser    // [2:0] byte_class, [5:3] status
);

    // Input stage: one word waiting to be decoded.
    logic                  in_valid_reg;
    logic                  in_valid_next;
    logic [7:0]            in_byte_reg;
    logic                  in_end_reg;

    // Decoder state carried from word to word.
    u8sd_pkg::seq_state_t  state_reg;
    u8sd_pkg::seq_state_t  state_next;

    // Result stage.
    logic                  out_valid_reg;
    logic                  out_valid_next;
    u8sd_pkg::result_t     out_reg;
    u8sd_pkg::result_t     result_next;

    logic                  accept;
    logic                  fire;

    // The input stage advances whenever the result register is empty or being emptied,
    // so a fresh word can enter every cycle as long as the downstream side keeps up.
    assign fire     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;
    assign accept   = s_tvalid && s_tready;

    assign in_valid_next  = accept ? 1'b1 : (fire ? 1'b0 : in_valid_reg);
    assign out_valid_next = fire ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);

    u8sd_step u_step
    (
        .in_byte (in_byte_reg),
        .in_end  (in_end_reg),
        .cur     (state_reg),
        .nxt     (state_next),
        .res     (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (fire)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_byte_reg <= s_tdata;
            in_end_reg  <= s_tlast;
        end
        if (fire)
        begin
            out_reg <= result_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_reg.code_point, out_reg.dropped_length, out_reg.byte_offset};
    assign m_tuser  = {out_reg.status, out_reg.byte_class};

`ifndef SYNTH
    // With no open sequence, nothing of a partial sequence may linger.
    a_closed_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.collected == 2'd0) |->
            (state_reg.remaining == 2'd0 && state_reg.seq_len == 3'd0 &&
             state_reg.partial == '0))
        else $error("closed sequence carries leftover state");

    // An open sequence always accounts for its full length.
    a_open_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.collected != 2'd0) |->
            ((3'(state_reg.collected) + 3'(state_reg.remaining)) == state_reg.seq_len))
        else $error("open sequence counts disagree with its length");

    // A word waiting in the input stage stays until it is decoded.
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !fire) |=> in_valid_reg)
        else $error("input word lost while result side stalled");

    // A finished code point is always a legal scalar value.
    a_cp_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.status == u8sd_pkg::ST_DONE) |->
            (out_reg.code_point <= u8sd_pkg::CP_MAX))
        else $error("decoded code point out of range");

    // End markers report the ASCII class code and a zero value.
    a_end_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.status == u8sd_pkg::ST_END) |->
            (out_reg.byte_class == u8sd_pkg::CLS_ASCII && out_reg.code_point == '0))
        else $error("end marker result carries stray fields");
`endif

endmodule
